### rtl/upd_pkg.sv
// shared types, constants and helper functions of the url percent decoder
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

   // character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // most words one input word can complete
   localparam int unsigned MAX_WORDS = 3;
   localparam int unsigned SLOT_W    = $clog2(MAX_WORDS + 1);

   // bundle queue between front and back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } upd_phase_type;

   // decoded output words of one input word
   typedef struct packed {
      logic [MAX_WORDS-1:0][7:0] bytes;
      logic [SLOT_W-1:0]         count;
      logic                      last;
   } upd_bundle_type;

   // queue status seen by front and back
   typedef struct packed {
      logic empty;
      logic full;
   } upd_qstat_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   // nibble value of a hex digit character
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         hex_value = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_value = c[3:0] + 4'd9;
      end else begin
         hex_value = 4'd0;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/url_percent_decoder_unit.sv
// top level of the url percent decoder
//
//  channel  | ports                               | word
//  ---------+-------------------------------------+------------------------------
//  request  | push, full, req_data                | one raw character + last flag
//  response | pop, empty, rsp_data                | one decoded character + last
//  csr      | csr_we, csr_wdata                   | plus_as_space mode bit
//
// one request word is taken per cycle while the bundle queue has room
// each request word yields zero to three response words, given out one per cycle while pop is held
// the back part's single output word per cycle, given pop, sets the sustained rate: three-word
//   flushes hold the input back once the four-entry bundle queue fills
// the front and back stall independently; full depends only on queue fill
// synchronous active-high reset clears escape state, mode bit and queue
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   // request side
   input  wire logic             push,
   output logic                  full,
   input  wire upd_pkg::req_type req_data,
   // response side
   input  wire logic             pop,
   output logic                  empty,
   output upd_pkg::rsp_type      rsp_data,
   // mode register
   input  wire logic             csr_we,
   input  wire logic             csr_wdata
);

   upd_pkg::upd_bundle_type fr_bundle;   // words decoded from one request word
   logic                    fr_we;       // request word taken and its bundle holds at least one word
   upd_pkg::upd_bundle_type q_head;
   upd_pkg::upd_qstat_type  q_stat;
   logic                    q_rd;
   logic                    accept;

   // request word is taken when the queue has room
   assign full   = q_stat.full;
   assign accept = push && !q_stat.full;

   // classification and escape tracking
   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .bundle    (fr_bundle),
      .bundle_we (fr_we)
   );

   // decouples the front from response back-pressure
   upd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fr_we),
      .wr_data (fr_bundle),
      .rd_en   (q_rd),
      .rd_data (q_head),
      .stat    (q_stat)
   );

   // serializes bundles onto the response port
   upd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_data (q_head),
      .q_stat (q_stat),
      .q_rd   (q_rd),
      .pop    (pop),
      .empty  (empty),
      .rsp    (rsp_data)
   );

   a_no_lost_word: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_data.in_last) |-> fr_we)
      else $error("end of string word dropped");

endmodule

`default_nettype wire

### rtl/upd_front.sv
// front part: escape tracking, classification of one input word into a bundle
`timescale 1ns / 1ps
`default_nettype none

module upd_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire upd_pkg::req_type        req,
   input  wire logic                    csr_we,
   input  wire logic                    csr_wdata,
   output upd_pkg::upd_bundle_type      bundle,
   output logic                         bundle_we
);

   upd_pkg::upd_phase_type phase_ff, phase_in;
   logic [7:0]             held_ff, held_in;
   logic                   plus_ff, plus_in;

   always_comb begin
      upd_pkg::upd_bundle_type   b_v;
      logic [upd_pkg::SLOT_W-1:0] n_v;
      logic                       fresh_v;
      upd_pkg::upd_phase_type     ph_v;

      b_v       = '0;
      n_v       = '0;
      fresh_v   = 1'b0;
      ph_v      = upd_pkg::PH_IDLE;
      held_in   = held_ff;

      case (phase_ff)
         upd_pkg::PH_PCT: begin
            if (upd_pkg::is_hex(req.in_byte)) begin
               held_in = req.in_byte;
               ph_v    = upd_pkg::PH_DIGIT;
            end else begin
               b_v.bytes[n_v] = upd_pkg::CH_PERCENT;
               n_v            = n_v + 1'b1;
               fresh_v        = 1'b1;
            end
         end
         upd_pkg::PH_DIGIT: begin
            if (upd_pkg::is_hex(req.in_byte)) begin
               b_v.bytes[n_v] = {upd_pkg::hex_value(held_ff),
                                 upd_pkg::hex_value(req.in_byte)};
               n_v            = n_v + 1'b1;
            end else begin
               b_v.bytes[n_v] = upd_pkg::CH_PERCENT;
               n_v            = n_v + 1'b1;
               b_v.bytes[n_v] = held_ff;
               n_v            = n_v + 1'b1;
               fresh_v        = 1'b1;
            end
            held_in = '0;
         end
         default: begin
            fresh_v = 1'b1;
         end
      endcase

      if (fresh_v) begin
         if (req.in_byte == upd_pkg::CH_PERCENT) begin
            ph_v = upd_pkg::PH_PCT;
         end else if (req.in_byte == upd_pkg::CH_PLUS && plus_ff) begin
            b_v.bytes[n_v] = upd_pkg::CH_SPACE;
            n_v            = n_v + 1'b1;
         end else begin
            b_v.bytes[n_v] = req.in_byte;
            n_v            = n_v + 1'b1;
         end
      end

      // end of string flushes whatever is held
      if (req.in_last) begin
         if (ph_v == upd_pkg::PH_PCT) begin
            b_v.bytes[n_v] = upd_pkg::CH_PERCENT;
            n_v            = n_v + 1'b1;
         end else if (ph_v == upd_pkg::PH_DIGIT) begin
            b_v.bytes[n_v] = upd_pkg::CH_PERCENT;
            n_v            = n_v + 1'b1;
            b_v.bytes[n_v] = held_in;
            n_v            = n_v + 1'b1;
         end
         ph_v    = upd_pkg::PH_IDLE;
         held_in = '0;
      end

      b_v.count = n_v;
      b_v.last  = req.in_last;
      bundle    = b_v;
      bundle_we = accept && (n_v != '0);

      phase_in = accept ? ph_v : phase_ff;
      if (!accept) begin
         held_in = held_ff;
      end
      plus_in = csr_we ? csr_wdata : plus_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_IDLE;
         held_ff  <= '0;
         plus_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         plus_ff  <= plus_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_last) |=> (phase_ff == upd_pkg::PH_IDLE && held_ff == '0))
      else $error("escape state not cleared at end of string");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_last) |-> bundle_we)
      else $error("end of string produced no word");

   a_digit_held: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == upd_pkg::PH_DIGIT) |-> upd_pkg::is_hex(held_ff))
      else $error("held digit is not hex");

endmodule

`default_nettype wire

### rtl/upd_queue.sv
// short bundle queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module upd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  wire upd_pkg::upd_bundle_type wr_data,
   input  wire logic                    rd_en,
   output upd_pkg::upd_bundle_type      rd_data,
   output upd_pkg::upd_qstat_type       stat
);

   upd_pkg::upd_bundle_type mem_ff [upd_pkg::QDEPTH];

   logic [upd_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [upd_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [upd_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wr_en ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = rd_en ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
      stat.empty = (cnt_ff == '0);
      stat.full  = (cnt_ff == upd_pkg::QCNT_W'(upd_pkg::QDEPTH));
      rd_data    = mem_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !stat.full)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !stat.empty)
      else $error("read from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance");

endmodule

`default_nettype wire

### rtl/upd_back.sv
// back part: holds one bundle and hands its words out one per pop
`timescale 1ns / 1ps
`default_nettype none

module upd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire upd_pkg::upd_bundle_type q_data,
   input  wire upd_pkg::upd_qstat_type  q_stat,
   output logic                         q_rd,
   input  wire logic                    pop,
   output logic                         empty,
   output upd_pkg::rsp_type             rsp
);

   upd_pkg::upd_bundle_type    cur_ff, cur_in;
   logic [upd_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                       busy_ff, busy_in;
   logic                       at_end;

   always_comb begin
      at_end  = (idx_ff == cur_ff.count - 1'b1);
      q_rd    = 1'b0;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;

      if (!busy_ff || (pop && at_end)) begin
         // current bundle done or none held: take the next one
         busy_in = !q_stat.empty;
         q_rd    = !q_stat.empty;
         cur_in  = q_data;
         idx_in  = '0;
      end else if (pop) begin
         idx_in = idx_ff + 1'b1;
      end

      empty        = !busy_ff;
      rsp.out_byte = cur_ff.bytes[idx_ff];
      rsp.out_last = cur_ff.last && at_end;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.count != '0 && idx_ff < cur_ff.count))
      else $error("word index outside held bundle");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp.out_last) |-> at_end)
      else $error("last marked before bundle end");

endmodule

`default_nettype wire
